[hdl/owb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the one-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

	// request kinds carried on the slave-side tuser
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_RESET = 2'd1;
	localparam logic [1:0] REQ_WRITE = 2'd2;
	localparam logic [1:0] REQ_READ  = 2'd3;

	localparam int UsW = 10;
	localparam int ResW = 13;
	localparam int InDataW = 16;
	localparam int OutDataW = 16;

	// one result word
	typedef struct packed {
		logic       rejected;
		logic [7:0] read_data;
		logic       device_present;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} owb_res_t;

	// one input word after the input register
	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] data_byte;
		logic       line_level;
	} owb_req_t;

endpackage

[hdl/owb_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_seq
// Bus sequencer: prescaler, slot timer and phase control, one word per step.
// ----------------------------------------------------------------------------
module owb_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [owb_pkg::UsW-1:0]   cfg_wdata,
	input  logic                      step,
	input  owb_pkg::owb_req_t         req,
	output owb_pkg::owb_res_t         res
);

	// phase codes
	localparam logic [3:0] PH_IDLE        = 4'd0;
	localparam logic [3:0] PH_RST_LOW     = 4'd1;
	localparam logic [3:0] PH_RST_WAIT    = 4'd2;
	localparam logic [3:0] PH_RST_RECOVER = 4'd3;
	localparam logic [3:0] PH_WR_LOW      = 4'd4;
	localparam logic [3:0] PH_WR_HIGH     = 4'd5;
	localparam logic [3:0] PH_RD_LOW      = 4'd6;
	localparam logic [3:0] PH_RD_WAIT     = 4'd7;
	localparam logic [3:0] PH_RD_TAIL     = 4'd8;

	// slot timing in microseconds
	localparam logic [9:0] RESET_LOW_US     = 10'd480;
	localparam logic [9:0] PRESENCE_WAIT_US = 10'd70;
	localparam logic [9:0] RESET_RECOVER_US = 10'd410;
	localparam logic [9:0] ONE_LOW_US       = 10'd6;
	localparam logic [9:0] ONE_HIGH_US      = 10'd64;
	localparam logic [9:0] ZERO_LOW_US      = 10'd60;
	localparam logic [9:0] ZERO_HIGH_US     = 10'd10;
	localparam logic [9:0] READ_LOW_US      = 10'd6;
	localparam logic [9:0] READ_WAIT_US     = 10'd9;
	localparam logic [9:0] READ_TAIL_US     = 10'd55;

	logic [owb_pkg::UsW-1:0] cpm_q;
	logic [3:0]              phase_q, phase_d;
	logic [owb_pkg::UsW-1:0] us_q, us_d;
	logic [owb_pkg::UsW-1:0] pre_q, pre_d;
	logic [2:0]              bit_q, bit_d;
	logic [7:0]              shift_q, shift_d;
	logic                    pres_q, pres_d;
	logic                    done, rej;
	logic [7:0]              rd_out;
	logic [owb_pkg::UsW:0]   pre_inc;
	logic [owb_pkg::UsW-1:0] us_inc;
	logic [9:0]              len;
	logic                    cur_bit;

	// length of the running phase
	always_comb begin
		cur_bit = shift_q[bit_q];
		case (phase_q)
			PH_RST_LOW:     len = RESET_LOW_US;
			PH_RST_WAIT:    len = PRESENCE_WAIT_US;
			PH_RST_RECOVER: len = RESET_RECOVER_US;
			PH_WR_LOW:      len = cur_bit ? ONE_LOW_US : ZERO_LOW_US;
			PH_WR_HIGH:     len = cur_bit ? ONE_HIGH_US : ZERO_HIGH_US;
			PH_RD_LOW:      len = READ_LOW_US;
			PH_RD_WAIT:     len = READ_WAIT_US;
			PH_RD_TAIL:     len = READ_TAIL_US;
			default:        len = 10'd1;
		endcase
	end

	// next state for one word
	always_comb begin
		phase_d = phase_q;
		us_d    = us_q;
		pre_d   = pre_q;
		bit_d   = bit_q;
		shift_d = shift_q;
		pres_d  = pres_q;
		done    = 1'b0;
		rej     = 1'b0;
		rd_out  = 8'd0;
		pre_inc = {1'b0, pre_q} + 11'd1;
		us_inc  = us_q + 10'd1;
		if (step) begin
			if (req.req_type != owb_pkg::REQ_TICK) begin
				if (phase_q != PH_IDLE) begin
					rej = 1'b1;
				end else begin
					us_d  = '0;
					pre_d = '0;
					bit_d = 3'd0;
					case (req.req_type)
						owb_pkg::REQ_RESET: begin
							pres_d  = 1'b0;
							phase_d = PH_RST_LOW;
						end
						owb_pkg::REQ_WRITE: begin
							shift_d = req.data_byte;
							phase_d = PH_WR_LOW;
						end
						default: begin
							shift_d = 8'd0;
							phase_d = PH_RD_LOW;
						end
					endcase
				end
			end else if (phase_q != PH_IDLE) begin
				if (pre_inc >= {1'b0, cpm_q}) begin
					pre_d = '0;
					us_d  = us_inc;
					if (us_inc >= len) begin
						us_d = '0;
						case (phase_q)
							PH_RST_LOW: phase_d = PH_RST_WAIT;
							PH_RST_WAIT: begin
								pres_d  = ~req.line_level;
								phase_d = PH_RST_RECOVER;
							end
							PH_RST_RECOVER: begin
								phase_d = PH_IDLE;
								done    = 1'b1;
							end
							PH_WR_LOW: phase_d = PH_WR_HIGH;
							PH_RD_LOW: phase_d = PH_RD_WAIT;
							PH_RD_WAIT: begin
								if (req.line_level) begin
									shift_d[bit_q] = 1'b1;
								end
								phase_d = PH_RD_TAIL;
							end
							PH_WR_HIGH, PH_RD_TAIL: begin
								if (bit_q == 3'd7) begin
									bit_d   = 3'd0;
									phase_d = PH_IDLE;
									done    = 1'b1;
									if (phase_q == PH_RD_TAIL) begin
										rd_out = shift_q;
									end
								end else begin
									bit_d   = bit_q + 3'd1;
									phase_d = (phase_q == PH_WR_HIGH) ? PH_WR_LOW : PH_RD_LOW;
								end
							end
							default: phase_d = PH_IDLE;
						endcase
					end
				end else begin
					pre_d = pre_inc[owb_pkg::UsW-1:0];
				end
			end
		end
	end

	// result word from the state after this word
	always_comb begin
		res.drive_low      = (phase_d == PH_RST_LOW) || (phase_d == PH_WR_LOW) ||
		                     (phase_d == PH_RD_LOW);
		res.busy_res       = (phase_d != PH_IDLE);
		res.done_res       = done;
		res.device_present = pres_d;
		res.read_data      = rd_out;
		res.rejected       = rej;
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpm_q <= 10'd100;
		end else if (cfg_we) begin
			cpm_q <= cfg_wdata;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			us_q    <= '0;
			pre_q   <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			pres_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			us_q    <= us_d;
			pre_q   <= pre_d;
			bit_q   <= bit_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
		end
	end

	// a rejected word leaves the sequence untouched
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && rej) |=> (phase_q == $past(phase_q)) && (bit_q == $past(bit_q)))
		else $error("rejected command changed the sequence");

	// a finished sequence always returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && done) |=> (phase_q == PH_IDLE) && (bit_q == 3'd0))
		else $error("sequence ended outside idle");

	// slot index only moves during byte phases
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) || (phase_q == PH_RST_LOW) || (phase_q == PH_RST_WAIT) ||
		(phase_q == PH_RST_RECOVER) |-> (bit_q == 3'd0))
		else $error("bit index set outside a byte transfer");

	// prescaler stays cleared while idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (pre_q == '0) && (us_q == '0))
		else $error("timers running while idle");

endmodule

[hdl/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: reset/presence, byte write and byte read slots.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one word per cycle when not stalled: tuser carries the
//   request kind (tick, reset pulse, write byte, read byte), tdata the byte
//   to send and the sampled line level. Ticks advance a prescaler of cfg_wdata
//   ticks per microsecond; the bus timing counts in those microseconds.
//   Master side returns exactly one result word per accepted word: drive
//   level for the open-drain pad, busy, done, presence, read byte, and a
//   reject flag for a command sent while a sequence runs.
//   Each word is held in an input register, the sequencer settles the
//   next state in one pass, and the result lands in a two-entry output
//   queue. Throughput is one word per cycle while the queue has room, set
//   by the single-pass sequencer step.
//   When the receiver stalls, the queue absorbs results and s_axis_tready
//   drops once the queue and input register are full; nothing is lost.
//   Reset clears the sequencer to idle, the prescale register to 100 and
//   empties both the input register and the queue.
//   Write cfg_we only while the block is idle with no words in flight.
// ----------------------------------------------------------------------------
module one_wire_bus_master (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [owb_pkg::UsW-1:0]        cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// data_byte[7:0], line_level[8], zero fill
	input  logic [owb_pkg::InDataW-1:0]    s_axis_tdata,
	// req_type[1:0]
	input  logic [1:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// drive_low[0], busy_res[1], done_res[2], device_present[3],
	// read_data[11:4], rejected[12], zero fill
	output logic [owb_pkg::OutDataW-1:0]   m_axis_tdata
);

	logic              valid_s1;
	owb_pkg::owb_req_t req_s1;
	logic              fire_s1;
	owb_pkg::owb_res_t res;
	owb_pkg::owb_res_t queue_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	// input register advances when the queue has room
	assign fire_s1       = valid_s1 && (count_q != 2'd2);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.req_type   <= s_axis_tuser;
			req_s1.data_byte  <= s_axis_tdata[7:0];
			req_s1.line_level <= s_axis_tdata[8];
		end
	end

	// sequencer step
	owb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (fire_s1),
		.req       (req_s1),
		.res       (res)
	);

	// output queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (fire_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, fire_s1} - {1'b0, pop};
		end
	end

	// output queue storage
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			queue_q[wr_ptr_q] <= res;
		end
	end

	assign m_axis_tvalid = (count_q != 2'd0);
	assign m_axis_tdata  = {{(owb_pkg::OutDataW - owb_pkg::ResW){1'b0}}, queue_q[rd_ptr_q]};

	// queue never over- or underflows
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd3))
		else $error("output queue count out of range");

	// a stored result is not dropped while the receiver stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("pending result vanished");

	// a full queue holds the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !fire_s1)
		else $error("push into full queue");

endmodule

[bench/one_wire_bus_master_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master_tb
// Self-checking bench for the one-wire bus master. Every accepted word runs
// through a cycle-free model of the sequencer, and the status it produces is
// queued. Each status word that leaves the block is compared field by field
// with the oldest queued one. Directed tests cover idle ticks, a reset pulse
// with presence and busy rejects, a write byte with a zero prescale setting
// and a read byte with random line levels and a prescale change mid-byte,
// all under random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module one_wire_bus_master_tb;

	localparam int CYCLE_LIMIT = 200000;

	// bus timing in microseconds
	localparam int T_RST_LOW   = 480;
	localparam int T_PRES_WAIT = 70;
	localparam int T_RST_REC   = 410;
	localparam int T_ONE_LOW   = 6;
	localparam int T_ONE_HIGH  = 64;
	localparam int T_ZERO_LOW  = 60;
	localparam int T_ZERO_HIGH = 10;
	localparam int T_RD_LOW    = 6;
	localparam int T_RD_WAIT   = 9;
	localparam int T_RD_TAIL   = 55;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_RST_LOW,
		SEQ_RST_WAIT,
		SEQ_RST_REC,
		SEQ_WR_LOW,
		SEQ_WR_HIGH,
		SEQ_RD_LOW,
		SEQ_RD_WAIT,
		SEQ_RD_TAIL
	} seq_phase_e;

	typedef enum int {LINE_RANDOM, LINE_LOW, LINE_HIGH} line_mode_e;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         cfg_we = 1'b0;
	logic [owb_pkg::UsW-1:0]      cfg_wdata = '0;
	logic                         s_axis_tvalid = 1'b0;
	logic                         s_axis_tready;
	// data_byte[7:0], line_level[8], zero fill
	logic [owb_pkg::InDataW-1:0]  s_axis_tdata = '0;
	// req_type[1:0]
	logic [1:0]                   s_axis_tuser = owb_pkg::REQ_TICK;
	logic                         m_axis_tvalid;
	logic                         m_axis_tready = 1'b0;
	// drive_low[0], busy_res[1], done_res[2], device_present[3],
	// read_data[11:4], rejected[12], zero fill
	logic [owb_pkg::OutDataW-1:0] m_axis_tdata;

	// model state
	seq_phase_e                   seq_phase = SEQ_IDLE;
	logic [9:0]                   us_count = '0;
	logic [9:0]                   pre_count = '0;
	logic [2:0]                   slot_idx = '0;
	logic [7:0]                   slot_byte = '0;
	logic                         presence_flag = 1'b0;
	logic [owb_pkg::UsW-1:0]      clk_per_us = 10'd100;

	owb_pkg::owb_res_t            pending_status[$];
	int                           fault_count = 0;

	one_wire_bus_master dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic pick_line(line_mode_e mode);
		case (mode)
			LINE_LOW: return 1'b0;
			LINE_HIGH: return 1'b1;
			default: return 1'($urandom_range(0, 1));
		endcase
	endfunction

	// length of the current phase in microseconds
	function automatic int slot_length();
		logic b;
		b = slot_byte[slot_idx];
		case (seq_phase)
			SEQ_RST_LOW: return T_RST_LOW;
			SEQ_RST_WAIT: return T_PRES_WAIT;
			SEQ_RST_REC: return T_RST_REC;
			SEQ_WR_LOW: return b ? T_ONE_LOW : T_ZERO_LOW;
			SEQ_WR_HIGH: return b ? T_ONE_HIGH : T_ZERO_HIGH;
			SEQ_RD_LOW: return T_RD_LOW;
			SEQ_RD_WAIT: return T_RD_WAIT;
			SEQ_RD_TAIL: return T_RD_TAIL;
			default: return 1;
		endcase
	endfunction

	// move to the next phase, returns 1 when the sequence ends
	function automatic bit leave_phase(logic line);
		case (seq_phase)
			SEQ_RST_LOW: seq_phase = SEQ_RST_WAIT;
			SEQ_RST_WAIT: begin
				presence_flag = ~line;
				seq_phase = SEQ_RST_REC;
			end
			SEQ_RST_REC: begin
				seq_phase = SEQ_IDLE;
				return 1'b1;
			end
			SEQ_WR_LOW: seq_phase = SEQ_WR_HIGH;
			SEQ_RD_LOW: seq_phase = SEQ_RD_WAIT;
			SEQ_RD_WAIT: begin
				if (line)
					slot_byte[slot_idx] = 1'b1;
				seq_phase = SEQ_RD_TAIL;
			end
			SEQ_WR_HIGH, SEQ_RD_TAIL: begin
				if (slot_idx == 3'd7) begin
					slot_idx = '0;
					seq_phase = SEQ_IDLE;
					return 1'b1;
				end
				slot_idx = slot_idx + 3'd1;
				seq_phase = (seq_phase == SEQ_WR_HIGH) ? SEQ_WR_LOW : SEQ_RD_LOW;
			end
			default: seq_phase = SEQ_IDLE;
		endcase
		return 1'b0;
	endfunction

	// advance the model by one word, return the status it should produce
	function automatic owb_pkg::owb_res_t step_bus_master(owb_pkg::owb_req_t w);
		owb_pkg::owb_res_t r;
		logic              from_read;
		r = '0;
		from_read = (seq_phase == SEQ_RD_TAIL);
		if (w.req_type != owb_pkg::REQ_TICK) begin
			if (seq_phase != SEQ_IDLE) begin
				r.rejected = 1'b1;
			end else begin
				us_count = '0;
				pre_count = '0;
				slot_idx = '0;
				case (w.req_type)
					owb_pkg::REQ_RESET: begin
						presence_flag = 1'b0;
						seq_phase = SEQ_RST_LOW;
					end
					owb_pkg::REQ_WRITE: begin
						slot_byte = w.data_byte;
						seq_phase = SEQ_WR_LOW;
					end
					default: begin
						slot_byte = '0;
						seq_phase = SEQ_RD_LOW;
					end
				endcase
			end
		end else if (seq_phase != SEQ_IDLE) begin
			// prescaler, a setting of zero behaves like one
			if (int'(pre_count) + 1 >= int'(clk_per_us)) begin
				pre_count = '0;
				us_count = us_count + 10'd1;
				if (int'(us_count) >= slot_length()) begin
					us_count = '0;
					if (leave_phase(w.line_level)) begin
						r.done_res = 1'b1;
						if (from_read)
							r.read_data = slot_byte;
					end
				end
			end else begin
				pre_count = pre_count + 10'd1;
			end
		end
		r.drive_low = (seq_phase inside {SEQ_RST_LOW, SEQ_WR_LOW, SEQ_RD_LOW});
		r.busy_res = (seq_phase != SEQ_IDLE);
		r.device_present = presence_flag;
		return r;
	endfunction

	// offer one word after a random gap, predict once it is taken
	task automatic send_word(input logic [1:0] kind, input logic [7:0] data,
			input logic line);
		owb_pkg::owb_req_t w;
		int                gap;
		w.req_type = kind;
		w.data_byte = data;
		w.line_level = line;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {{(owb_pkg::InDataW - 9){1'b0}}, line, data};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pending_status.push_back(step_bus_master(w));
	endtask

	// one tick or, now and then, a stray command
	task automatic send_tick(input line_mode_e mode, input int stray_pct);
		if ($urandom_range(0, 99) < stray_pct)
			send_word(2'($urandom_range(owb_pkg::REQ_RESET, owb_pkg::REQ_READ)),
				8'($urandom), 1'($urandom));
		else
			send_word(owb_pkg::REQ_TICK, 8'($urandom), pick_line(mode));
	endtask

	// tick until the running sequence is over, with optional stray commands
	task automatic tick_until_idle(input line_mode_e mode, input int stray_pct);
		while (seq_phase != SEQ_IDLE)
			send_tick(mode, stray_pct);
	endtask

	// up to a given number of words while the sequence runs
	task automatic tick_n(input line_mode_e mode, input int stray_pct, input int n);
		repeat (n) begin
			if (seq_phase != SEQ_IDLE)
				send_tick(mode, stray_pct);
		end
	endtask

	// drain everything, then write the prescale register
	task automatic set_rate(input logic [owb_pkg::UsW-1:0] value);
		s_axis_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		clk_per_us = value;
	endtask

	task automatic test_idle_words();
		send_word(owb_pkg::REQ_TICK, 8'h00, 1'b0);
		send_word(owb_pkg::REQ_TICK, 8'hFF, 1'b1);
		send_word(owb_pkg::REQ_TICK, 8'h5A, 1'b0);
		send_word(owb_pkg::REQ_TICK, 8'hA5, 1'b1);
	endtask

	// presence found, commands while busy are refused
	task automatic test_reset_pulse();
		set_rate(10'd1);
		send_word(owb_pkg::REQ_RESET, 8'h00, 1'b1);
		send_word(owb_pkg::REQ_WRITE, 8'hFF, 1'b1);
		send_word(owb_pkg::REQ_READ, 8'h00, 1'b0);
		send_word(owb_pkg::REQ_RESET, 8'h3C, 1'b1);
		tick_until_idle(LINE_LOW, 1);
	endtask

	// both slot kinds, with a prescale setting of zero acting like one
	task automatic test_write_slots();
		set_rate(10'd0);
		send_word(owb_pkg::REQ_WRITE, 8'hA5, 1'b0);
		tick_until_idle(LINE_RANDOM, 2);
	endtask

	// random line levels, the start of the first slot at a slower rate
	task automatic test_read_slots();
		set_rate(10'd3);
		send_word(owb_pkg::REQ_READ, 8'h96, 1'b1);
		tick_n(LINE_RANDOM, 2, 60);
		set_rate(10'd1);
		tick_until_idle(LINE_RANDOM, 2);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fault_count++;
		end
	endtask

	// compare each status word with the oldest prediction
	always @(posedge clk) begin
		owb_pkg::owb_res_t want;
		owb_pkg::owb_res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_status.size() == 0) begin
				$error("status word with no prediction waiting");
				fault_count++;
			end else begin
				want = pending_status.pop_front();
				got = owb_pkg::owb_res_t'(m_axis_tdata[owb_pkg::ResW-1:0]);
				check_field("drive_low", want.drive_low, got.drive_low);
				check_field("busy_res", want.busy_res, got.busy_res);
				check_field("done_res", want.done_res, got.done_res);
				check_field("device_present", want.device_present, got.device_present);
				check_field("read_data", want.read_data, got.read_data);
				check_field("rejected", want.rejected, got.rejected);
			end
		end
	end

	// receiver stalls
	initial begin : rx_stall
		int hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				hold--;
			end else begin
				m_axis_tready <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	// run length guard
	initial begin : watchdog
		int cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("one_wire_bus_master_tb: errors");
		$finish;
	end

	// test sequence
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_words();
		test_reset_pulse();
		test_write_slots();
		test_read_slots();
		s_axis_tvalid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fault_count == 0)
			$display("one_wire_bus_master_tb: clean");
		else
			$display("one_wire_bus_master_tb: errors");
		$finish;
	end

endmodule

[one_wire_bus_master.f]
hdl/owb_pkg.sv
hdl/owb_seq.sv
hdl/one_wire_bus_master.sv
bench/one_wire_bus_master_tb.sv
